// ===== rtl/nfi_pkg.sv =====
// shared types, constants and saturation helpers for the newton forward interpolator
package nfi_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 16;

  // configuration register indexes
  localparam logic REG_ORIGIN = 1'b0;
  localparam logic REG_STEP   = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_EV_SST,
    S_EV_SW,
    S_EV_F,
    S_EV_M1,
    S_EV_CST,
    S_EV_CW,
    S_EV_M2,
    S_EV_T,
    S_EV_ACC,
    S_FIN
  } state_t;

  // clamp a sign and magnitude to signed 32 bits, returns {clamped, value}
  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(~mag[31:0] + 32'd1)};
    end else begin
      if (mag > 64'h0000_0000_7fff_ffff) r = {1'b1, 32'h7fff_ffff};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  // clamp a signed 34 bit value to signed 32 bits, returns {clamped, value}
  function automatic logic [32:0] sat_s34(input logic signed [33:0] v);
    logic [32:0] r;
    if (v > 34'sh0_7fff_ffff) r = {1'b1, 32'h7fff_ffff};
    else if (v < -34'sh0_8000_0000) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ===== rtl/newton_forward_interpolator_top.sv =====
// newton forward difference interpolator: sequencer, multiplier and table memories
// clear and reserved commands go straight to the result; load does one memory
//   read then write per difference order; evaluate waits on the 64 step serial
//   divider, once for s and once per order
// one item at a time: the next item is accepted once the result is registered
// reset: synchronous active low, empties the table, origin 0, step 1.0
module newton_forward_interpolator_top import nfi_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_sample_value,
  input  logic [31:0] in_query_x,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_interpolated_value,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t state_r, state_nxt;

  logic [31:0]        origin_r;
  logic [30:0]        step_r;
  logic [CW-1:0]      cnt_r, idx_r, k_r;
  logic [31:0]        cur_r, qx_r, s_r, f_r, c_r, sum_r, term_r, res_r;
  logic signed [63:0] prod_r;
  logic               sat_r;
  status_t            stat_r;
  logic               out_valid_r;
  logic [31:0]        out_val_r;
  status_t            out_stat_r;

  logic        t_re, t_we, l_re, l_we, div_start, div_done;
  logic [AW-1:0] l_raddr;
  logic [31:0] t_rdata, l_rdata, div_den;
  logic [63:0] div_num, div_q;
  logic        in_fire, out_free;
  cmd_t        cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      step_r   <= 31'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN: origin_r <= cfg_wdata;
        REG_STEP:   step_r   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // difference table memories
  nfi_ram #(.DEPTH(MAX_POINTS), .AW(AW)) u_trail (
    .clk(clk), .we(t_we), .waddr(idx_r[AW-1:0]), .wdata(cur_r),
    .re(t_re), .raddr(idx_r[AW-1:0]), .rdata_r(t_rdata)
  );

  nfi_ram #(.DEPTH(MAX_POINTS), .AW(AW)) u_lead (
    .clk(clk), .we(l_we), .waddr(cnt_r[AW-1:0]), .wdata(cur_r),
    .re(l_re), .raddr(l_raddr), .rdata_r(l_rdata)
  );

  // shared serial divider
  nfi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done_r(div_done), .quo_r(div_q)
  );

  // arithmetic around the divider and multiplier
  logic signed [32:0] dx;
  logic [32:0]        dx_mag;
  logic [63:0]        prod_mag;
  logic               q_neg;
  logic [32:0]        q_sat, ld_sat, f_sat, t_sat, acc_sat;

  assign dx       = signed'({qx_r[31], qx_r}) - signed'({origin_r[31], origin_r});
  assign dx_mag   = dx[32] ? 33'(-dx) : 33'(dx);
  assign prod_mag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign div_num  = (state_r == S_EV_SST) ? (64'(dx_mag) << FRAC_BITS) : prod_mag;
  assign div_den  = (state_r == S_EV_SST) ? ((step_r == '0) ? 32'd1 : {1'b0, step_r})
                                          : (32'(k_r) << FRAC_BITS);
  assign q_neg    = (state_r == S_EV_SW) ? dx[32] : prod_r[63];
  assign q_sat    = sat_mag(q_neg, div_q);
  assign ld_sat   = sat_s34(signed'({{2{cur_r[31]}}, cur_r}) -
                            signed'({{2{t_rdata[31]}}, t_rdata}));
  assign f_sat    = sat_s34(signed'({{2{s_r[31]}}, s_r}) -
                            signed'(34'(k_r - CW'(1)) << FRAC_BITS));
  assign t_sat    = sat_mag(prod_r[63], prod_mag >> FRAC_BITS);
  assign acc_sat  = sat_s34(signed'({{2{sum_r[31]}}, sum_r}) +
                            signed'({{2{term_r[31]}}, term_r}));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            CMD_LOAD: state_nxt = (cnt_r >= CW'(MAX_POINTS)) ? S_FIN : S_LD_RD;
            CMD_EVAL: state_nxt = (cnt_r == '0) ? S_FIN : S_EV_SST;
            CMD_CLEAR, CMD_RSVD: state_nxt = S_FIN;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_LD_RD:  state_nxt = S_LD_WR;
      S_LD_WR:  state_nxt = (idx_r == cnt_r) ? S_FIN : S_LD_RD;
      S_EV_SST: state_nxt = S_EV_SW;
      S_EV_SW: begin
        if (div_done) state_nxt = (cnt_r == CW'(1)) ? S_FIN : S_EV_F;
      end
      S_EV_F:   state_nxt = S_EV_M1;
      S_EV_M1:  state_nxt = S_EV_CST;
      S_EV_CST: state_nxt = S_EV_CW;
      S_EV_CW: begin
        if (div_done) state_nxt = S_EV_M2;
      end
      S_EV_M2:  state_nxt = S_EV_T;
      S_EV_T:   state_nxt = S_EV_ACC;
      S_EV_ACC: state_nxt = (k_r + CW'(1) == cnt_r) ? S_FIN : S_EV_F;
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory and divider strobes
  always_comb begin
    t_re      = (state_r == S_LD_RD);
    t_we      = (state_r == S_LD_WR);
    l_we      = (state_r == S_LD_WR) && (idx_r == cnt_r);
    l_re      = (state_r == S_EV_SST) || (state_r == S_EV_F);
    l_raddr   = (state_r == S_EV_F) ? k_r[AW-1:0] : '0;
    div_start = (state_r == S_EV_SST) || (state_r == S_EV_CST);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && cmd == CMD_CLEAR) cnt_r <= '0;
      if (state_r == S_LD_WR && idx_r == cnt_r) cnt_r <= cnt_r + CW'(1);
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        sat_r  <= 1'b0;
        res_r  <= '0;
        stat_r <= ST_OK;
        cur_r  <= in_sample_value;
        qx_r   <= in_query_x;
        idx_r  <= '0;
        k_r    <= CW'(1);
        c_r    <= 32'(1) << FRAC_BITS;
        if (cmd == CMD_LOAD && cnt_r >= CW'(MAX_POINTS)) stat_r <= ST_FULL;
        if (cmd == CMD_EVAL && cnt_r == '0) stat_r <= ST_EMPTY;
      end
      S_LD_WR: begin
        cur_r <= ld_sat[31:0];
        if (idx_r == cnt_r) begin
          stat_r <= sat_r ? ST_SAT : ST_OK;
        end else begin
          sat_r <= sat_r | ld_sat[32];
          idx_r <= idx_r + CW'(1);
        end
      end
      S_EV_SW: begin
        if (div_done) begin
          s_r   <= q_sat[31:0];
          sat_r <= q_sat[32];
          sum_r <= l_rdata;
          res_r <= l_rdata;
          stat_r <= q_sat[32] ? ST_SAT : ST_OK;
        end
      end
      S_EV_F: begin
        f_r   <= f_sat[31:0];
        sat_r <= sat_r | f_sat[32];
      end
      S_EV_M1: prod_r <= signed'(c_r) * signed'(f_r);
      S_EV_CW: begin
        if (div_done) begin
          c_r   <= q_sat[31:0];
          sat_r <= sat_r | q_sat[32];
        end
      end
      S_EV_M2: prod_r <= signed'(c_r) * signed'(l_rdata);
      S_EV_T: begin
        term_r <= t_sat[31:0];
        sat_r  <= sat_r | t_sat[32];
      end
      S_EV_ACC: begin
        sum_r  <= acc_sat[31:0];
        sat_r  <= sat_r | acc_sat[32];
        k_r    <= k_r + CW'(1);
        res_r  <= acc_sat[31:0];
        stat_r <= (sat_r || acc_sat[32]) ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_val_r  <= res_r;
      out_stat_r <= stat_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_interpolated_value = out_val_r;
  assign out_status             = out_stat_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS)) else $error("sample count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE) else $error("accepted item not worked on");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_interpolated_value == '0)
    else $error("empty table evaluate gave nonzero value");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_done) else $error("divider restarted while finishing");

endmodule

// ===== rtl/nfi_ram.sv =====
// single write port, single registered read port memory for difference entries
module nfi_ram import nfi_pkg::*; #(
  parameter int DEPTH = MAX_POINTS_DEF,
  parameter int AW    = $clog2(MAX_POINTS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata_r
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, data holds between reads
  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

endmodule

// ===== rtl/nfi_div.sv =====
// bit serial restoring divider, 64 bit magnitude by 32 bit magnitude
module nfi_div import nfi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done_r,
  output logic [63:0] quo_r
);

  logic        busy_r;
  logic [6:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [32:0] rem_sh;
  logic        ge;

  // one quotient bit per cycle while busy
  assign rem_sh = {rem_r, quo_r[63]};
  assign ge     = rem_sh >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      quo_r <= {quo_r[62:0], ge};
    end
  end

endmodule
